// ===== hw/rtl/bsa_pkg.sv =====
// Shared types and constants for the bitmap slot allocator.
// Item structs, field widths, action codes and register indexes.
// No dependencies.
package bsa_pkg;

    // Node geometry
    localparam int SLOTS      = 2048;
    localparam int WORD_BITS  = 64;
    localparam int WORDS      = SLOTS / WORD_BITS;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int WORD_IDX_W = $clog2(WORDS);

    // Field widths
    localparam int ACT_W      = 2;
    localparam int OFF_W      = 17;
    localparam int CNT_W      = 11;
    localparam int QNT_W      = 6;
    localparam int HDR_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Reset values of the configuration registers
    localparam logic [QNT_W-1:0] QUANTUM_RST = QNT_W'(16);
    localparam logic [HDR_W-1:0] HEADER_RST  = HDR_W'(304);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = CFG_IDX_W'(1);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INIT  = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_ALLOC = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_FREE  = ACT_W'(2);

    // Status codes
    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_REFUSED = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [OFF_W-1:0] chunk_offset;
    } req_item_t;

    typedef struct packed {
        logic             status;
        logic [OFF_W-1:0] alloc_offset;
        logic [CNT_W-1:0] free_slots;
        logic             node_unused;
    } rsp_item_t;

endpackage

// ===== hw/rtl/bitmap_slot_allocator_top.sv =====
// A full node refuses an alloc at once; otherwise alloc scans one bitmap word per cycle
// until it finds a free slot.
// One item at a time: the next item is taken once the result is in the output
// register. Init and free run a shared divider, one quotient bit per cycle; alloc
// scans the bitmap memory through its single read port.
// Reset (rst_n, async, active low) clears control state and the per-word valid
// flags, so the bitmap reads as all used at once; no clearing pass is needed.
//
// Bitmap slot allocator top level: sequencer, divider, bitmap memory, result register.
// Depends on bsa_pkg.
module bitmap_slot_allocator_top
    import bsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_item_t             req_item,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_item_t             rsp_item
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DIV      = 9'b000000010,
        S_HDR      = 9'b000000100,
        S_FILL     = 9'b000001000,
        S_SCAN     = 9'b000010000,
        S_MUL      = 9'b000100000,
        S_FREE_CHK = 9'b001000000,
        S_FREE_WR  = 9'b010000000,
        S_RESP     = 9'b100000000
    } state_t;

    localparam logic [SLOT_W-1:0] MAX_SLOT = SLOT_W'(SLOTS - 1);

    // Lowest set bit of a bitmap word
    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
                idx = BIT_IDX_W'(i);
        end
        return idx;
    endfunction

    state_t                 state_reg, state_next;
    logic [ACT_W-1:0]       op_reg, op_next;
    logic [QNT_W-1:0]       quantum_reg;
    logic [HDR_W-1:0]       header_reg;
    logic [OFF_W-1:0]       dq_reg, dq_next;
    logic [QNT_W-1:0]       rem_reg, rem_next;
    logic [4:0]             div_cnt_reg, div_cnt_next;
    logic [WORD_IDX_W-1:0]  scan_w_reg, scan_w_next;
    logic [WORD_IDX_W-1:0]  fill_w_reg, fill_w_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [SLOT_W-1:0]      hdr_reg, hdr_next;
    logic [CNT_W-1:0]       free_count_reg, free_count_next;
    logic [CNT_W-1:0]       cap_reg, cap_next;
    logic                   res_status_reg, res_status_next;
    logic [OFF_W-1:0]       res_offset_reg, res_offset_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_item_t              rsp_item_reg, rsp_item_next;

    // Bitmap memory, one flag per word marks it written since reset
    logic [WORD_BITS-1:0]   mem [WORDS];
    logic [WORDS-1:0]       word_vld_reg;
    logic [WORD_BITS-1:0]   rd_data_reg;
    logic                   rd_vld_reg;
    logic [WORD_IDX_W-1:0]  rd_addr;
    logic                   mem_we;
    logic [WORD_IDX_W-1:0]  mem_waddr;
    logic [WORD_BITS-1:0]   mem_wdata;
    logic [WORD_BITS-1:0]   rd_word;

    logic [QNT_W-1:0]       qeff;
    logic [QNT_W:0]         div_shift;
    logic                   div_bit;
    logic [SLOT_W-1:0]      hdr_cur;
    logic [OFF_W-1:0]       free_slot;
    logic                   free_ok;
    logic [BIT_IDX_W-1:0]   scan_bit;
    logic [WORD_BITS-1:0]   fill_word;
    logic [OFF_W-1:0]       prod;
    logic                   out_free;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // Shared datapath pieces
    assign qeff      = (quantum_reg == '0) ? QNT_W'(1) : quantum_reg;
    assign div_shift = {rem_reg, dq_reg[OFF_W-1]};
    assign div_bit   = (div_shift >= {1'b0, qeff});
    assign hdr_cur   = MAX_SLOT - SLOT_W'(cap_reg);
    assign free_slot = dq_reg - OFF_W'(1);
    assign free_ok   = (dq_reg != '0) && (free_slot >= OFF_W'(hdr_cur))
                       && (free_slot < OFF_W'(MAX_SLOT));
    assign rd_word   = rd_vld_reg ? rd_data_reg : '0;
    assign scan_bit  = lowest_set(rd_word);
    assign prod      = OFF_W'({1'b0, slot_reg} + {1'b0, {SLOT_W{1'b0}}} + 1'b1)
                       * OFF_W'(qeff);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // Fill pattern: slots at or above the header boundary are free
    always_comb
    begin
        if (fill_w_reg > hdr_reg[SLOT_W-1:BIT_IDX_W])
            fill_word = '1;
        else if (fill_w_reg == hdr_reg[SLOT_W-1:BIT_IDX_W])
            fill_word = {WORD_BITS{1'b1}} << hdr_reg[BIT_IDX_W-1:0];
        else
            fill_word = '0;
    end

    // Read address: prefetch word 0 while idle, next word while scanning, the freed slot's word in the free check
    always_comb
    begin
        case (state_reg)
            S_SCAN:     rd_addr = scan_w_reg + WORD_IDX_W'(1);
            S_FREE_CHK: rd_addr = free_slot[SLOT_W-1:BIT_IDX_W];
            default:    rd_addr = '0;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        scan_w_next     = scan_w_reg;
        fill_w_next     = fill_w_reg;
        slot_next       = slot_reg;
        hdr_next        = hdr_reg;
        free_count_next = free_count_reg;
        cap_next        = cap_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_item_next   = rsp_item_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_w_reg;
        mem_wdata       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = req_item.action;
                    res_status_next = STAT_DONE;
                    res_offset_next = '0;
                    rem_next        = '0;
                    div_cnt_next    = '0;
                    case (req_item.action)
                        ACT_INIT:
                        begin
                            dq_next    = OFF_W'(header_reg) + OFF_W'(qeff) - OFF_W'(1);
                            state_next = S_DIV;
                        end
                        ACT_FREE:
                        begin
                            dq_next    = req_item.chunk_offset;
                            state_next = S_DIV;
                        end
                        ACT_ALLOC:
                        begin
                            scan_w_next = '0;
                            if (free_count_reg == '0)
                            begin
                                res_status_next = STAT_REFUSED;
                                state_next      = S_RESP;
                            end
                            else
                                state_next = S_SCAN;
                        end
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end

            // One quotient bit per cycle, restoring
            S_DIV:
            begin
                dq_next      = {dq_reg[OFF_W-2:0], div_bit};
                rem_next     = div_bit ? QNT_W'(div_shift - {1'b0, qeff})
                                       : div_shift[QNT_W-1:0];
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'(OFF_W - 1))
                    state_next = (op_reg == ACT_INIT) ? S_HDR : S_FREE_CHK;
            end

            // Header slots: quotient minus one, saturated
            S_HDR:
            begin
                if (header_reg == '0 || dq_reg == '0)
                    hdr_next = '0;
                else if (dq_reg > OFF_W'(SLOTS))
                    hdr_next = MAX_SLOT;
                else
                    hdr_next = SLOT_W'(dq_reg - OFF_W'(1));
                fill_w_next = '0;
                state_next  = S_FILL;
            end

            // Rewrite every bitmap word
            S_FILL:
            begin
                mem_we      = 1'b1;
                mem_waddr   = fill_w_reg;
                mem_wdata   = fill_word;
                fill_w_next = fill_w_reg + WORD_IDX_W'(1);
                if (fill_w_reg == WORD_IDX_W'(WORDS - 1))
                begin
                    cap_next        = CNT_W'(MAX_SLOT - hdr_reg);
                    free_count_next = CNT_W'(MAX_SLOT - hdr_reg);
                    state_next      = S_RESP;
                end
            end

            // Examine one word per cycle, take its lowest free slot
            S_SCAN:
            begin
                if (rd_word != '0)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = scan_w_reg;
                    mem_wdata       = rd_word & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << scan_bit);
                    slot_next       = {scan_w_reg, scan_bit};
                    free_count_next = free_count_reg - CNT_W'(1);
                    state_next      = S_MUL;
                end
                else if (scan_w_reg == WORD_IDX_W'(WORDS - 1))
                begin
                    res_status_next = STAT_REFUSED;
                    state_next      = S_RESP;
                end
                else
                    scan_w_next = scan_w_reg + WORD_IDX_W'(1);
            end

            S_MUL:
            begin
                res_offset_next = prod[OFF_W-1:0];
                state_next      = S_RESP;
            end

            // Drop frees outside the usable range
            S_FREE_CHK:
            begin
                slot_next  = free_slot[SLOT_W-1:0];
                state_next = free_ok ? S_FREE_WR : S_RESP;
            end

            S_FREE_WR:
            begin
                if (!rd_word[slot_reg[BIT_IDX_W-1:0]])
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = slot_reg[SLOT_W-1:BIT_IDX_W];
                    mem_wdata       = rd_word | ({{(WORD_BITS-1){1'b0}}, 1'b1}
                                                 << slot_reg[BIT_IDX_W-1:0]);
                    free_count_next = free_count_reg + CNT_W'(1);
                end
                state_next = S_RESP;
            end

            // Hand the result to the output register once it is free
            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_item_next.status       = res_status_reg;
                    rsp_item_next.alloc_offset = res_offset_reg;
                    rsp_item_next.free_slots   = free_count_reg;
                    rsp_item_next.node_unused  = (free_count_reg == cap_reg);
                    state_next                 = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            quantum_reg    <= QUANTUM_RST;
            header_reg     <= HEADER_RST;
            free_count_reg <= '0;
            cap_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            word_vld_reg   <= '0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            cap_reg        <= cap_next;
            rsp_valid_reg  <= rsp_valid_next;
            rd_vld_reg     <= word_vld_reg[rd_addr];
            if (mem_we)
                word_vld_reg[mem_waddr] <= 1'b1;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QUANTUM: quantum_reg <= cfg_data[QNT_W-1:0];
                    REG_HEADER:  header_reg  <= cfg_data[HDR_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        div_cnt_reg    <= div_cnt_next;
        scan_w_reg     <= scan_w_next;
        fill_w_reg     <= fill_w_next;
        slot_reg       <= slot_next;
        hdr_reg        <= hdr_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        rsp_item_reg   <= rsp_item_next;
    end

    // Bitmap memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    // Free count never exceeds usable capacity
    a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= cap_reg)
        else $error("free count above capacity");

    // An accepted item blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("input not stalled after accept");

    // A refused allocation carries no offset
    a_refused_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_item_reg.status |-> rsp_item_reg.alloc_offset == '0)
        else $error("refused result with offset");

    // A new result is loaded only from the result state
    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result loaded outside result state");
`endif

endmodule

// ===== test/slot_alloc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bitmap slot allocator: watches the config port and both item channels.
// Keeps its own copy of the bitmap, free count and capacity and compares every result.
// Depends on bsa_pkg.
module slot_alloc_checker
    import bsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    input  logic                  req_stall,
    input  req_item_t             req_item,
    input  logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  rsp_item_t             rsp_item,
    output int                    mismatch_count,
    output int                    outstanding
);

    // Shadow node state and registers
    logic [SLOTS-1:0] free_map    = '0;
    int               avail_cnt   = 0;
    int               capacity    = 0;
    int               quantum     = QUANTUM_RST;
    int               header_len  = HEADER_RST;
    rsp_item_t        awaited_results[$];
    rsp_item_t        want;
    rsp_item_t        predicted;

    initial mismatch_count = 0;
    initial outstanding = 0;

    // Work out the result of one item and advance the shadow node
    task automatic predict_slot_result(input req_item_t req, output rsp_item_t rsp);
        int q;
        int hdr;
        int s;
        int chunk;
        int offset;
        logic refused;
        q = (quantum == 0) ? 1 : quantum;
        rsp = '0;
        rsp.status = STAT_DONE;
        case (req.action)
            ACT_INIT:
            begin
                hdr = 0;
                if (header_len != 0)
                    hdr = (header_len + q - 1) / q - 1;
                if (hdr > SLOTS - 1)
                    hdr = SLOTS - 1;
                free_map = '0;
                for (s = hdr; s < SLOTS; s++)
                    free_map[s] = 1'b1;
                capacity = SLOTS - 1 - hdr;
                avail_cnt = capacity;
            end
            ACT_ALLOC:
            begin
                refused = 1'b1;
                offset = 0;
                if (avail_cnt != 0)
                begin
                    for (s = 0; s < SLOTS && refused; s++)
                    begin
                        if (free_map[s])
                        begin
                            free_map[s] = 1'b0;
                            avail_cnt--;
                            offset = (s + 1) * q;
                            refused = 1'b0;
                        end
                    end
                end
                rsp.status = refused ? STAT_REFUSED : STAT_DONE;
                rsp.alloc_offset = refused ? '0 : OFF_W'(offset);
            end
            ACT_FREE:
            begin
                chunk = req.chunk_offset;
                hdr = SLOTS - 1 - capacity;
                if (chunk >= q)
                begin
                    s = chunk / q - 1;
                    // drop header slots, the top slot and anything beyond, and double frees
                    if (s >= hdr && s < SLOTS - 1 && !free_map[s])
                    begin
                        free_map[s] = 1'b1;
                        avail_cnt++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        rsp.free_slots = CNT_W'(avail_cnt);
        rsp.node_unused = (avail_cnt == capacity);
    endtask

    task automatic check_field(input string name, input logic [OFF_W-1:0] exp_val,
                               input logic [OFF_W-1:0] got_val);
        if (got_val !== exp_val)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, got_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map = '0;
            avail_cnt = 0;
            capacity = 0;
            quantum = QUANTUM_RST;
            header_len = HEADER_RST;
            awaited_results.delete();
            outstanding = 0;
        end
        else
        begin
            // Capture register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QUANTUM: quantum = cfg_data[QNT_W-1:0];
                    REG_HEADER:  header_len = cfg_data[HDR_W-1:0];
                    default:     ;
                endcase
            end
            // Compare an accepted result with the oldest expectation
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, rsp_item);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", OFF_W'(want.status), OFF_W'(rsp_item.status));
                    check_field("alloc_offset", want.alloc_offset, rsp_item.alloc_offset);
                    check_field("free_slots", OFF_W'(want.free_slots),
                                OFF_W'(rsp_item.free_slots));
                    check_field("node_unused", OFF_W'(want.node_unused),
                                OFF_W'(rsp_item.node_unused));
                end
            end
            // Predict the result of an accepted item
            if (req_valid && !req_stall)
            begin
                predict_slot_result(req_item, predicted);
                awaited_results.push_back(predicted);
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

// ===== test/tb_bitmap_slot_allocator_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the bitmap slot allocator: clock, reset, stimulus and verdict.
// Uses slot_alloc_checker for prediction and comparison; depends on bsa_pkg.
module tb_bitmap_slot_allocator_top;
    import bsa_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 70;
    localparam int OFF_MAX     = (1 << OFF_W) - 1;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 60;
    localparam logic [ACT_W-1:0] ACT_UNUSED = ACT_W'(3);

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_item_t             req_item  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_item_t             rsp_item;

    int mismatch_count;
    int outstanding;
    int cycle_count   = 0;
    int accepted_reqs = 0;
    bit quiet         = 1'b0;
    bit held          = 1'b0;

    // Register settings per random phase; -1 picks a random value
    int phase_quantum[PHASES] = '{16, 0, 2, 63, 1, 48, 4, -1, -1, 2};
    int phase_header[PHASES]  = '{304, 0, 4000, 8191, 4060, 4096, 8100, -1, -1, 4060};

    initial
    begin
        forever #5 clk = ~clk;
    end

    bitmap_slot_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    slot_alloc_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_item       (req_item),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_item       (rsp_item),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stall bursts plus one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!held && accepted_reqs >= HOLD_AFTER)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
                held = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < 15)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Offer one item, with an optional idle burst ahead of it
    task automatic send_req(input logic [ACT_W-1:0] act, input int chunk);
        req_item_t item;
        if (!quiet && $urandom_range(0, 99) < 25)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item.action = act;
        item.chunk_offset = OFF_W'(chunk);
        req_item <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        accepted_reqs++;
    endtask

    // Write a register once every result is back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int p;
        int i;
        int r;
        int q;
        int hdr_len;
        int q_eff;
        int low_slot;
        int allocs;
        int chunk;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: before init, then the usual paths under reset settings
        send_req(ACT_ALLOC, 0);
        send_req(ACT_FREE, 32);
        send_req(ACT_UNUSED, OFF_MAX);
        send_req(ACT_INIT, 0);
        send_req(ACT_ALLOC, 0);
        send_req(ACT_ALLOC, OFF_MAX);
        send_req(ACT_ALLOC, 0);
        send_req(ACT_FREE, 0);
        send_req(ACT_FREE, 15);
        send_req(ACT_FREE, 16);
        send_req(ACT_FREE, 32768);
        send_req(ACT_FREE, OFF_MAX);
        send_req(ACT_FREE, 327);
        send_req(ACT_FREE, 320);
        send_req(ACT_ALLOC, 0);
        send_req(ACT_FREE, 304);
        send_req(ACT_FREE, 336);
        send_req(ACT_FREE, 320);
        send_req(ACT_UNUSED, 0);
        // Zero quantum and no header
        write_reg(REG_QUANTUM, 0);
        write_reg(REG_HEADER, 0);
        send_req(ACT_INIT, 0);
        send_req(ACT_ALLOC, 0);
        send_req(ACT_FREE, 1);
        // Largest quantum and header
        write_reg(REG_QUANTUM, 63);
        write_reg(REG_HEADER, 8191);
        send_req(ACT_INIT, 0);
        send_req(ACT_ALLOC, 0);

        // Random phases: init, then mostly allocs and frees of live slots
        for (p = 0; p < PHASES; p++)
        begin
            if (p >= PHASES - 2)
                quiet = 1'b1;
            q = (phase_quantum[p] < 0) ? $urandom_range(0, 63) : phase_quantum[p];
            hdr_len = (phase_header[p] < 0) ? $urandom_range(0, 8191) : phase_header[p];
            write_reg(REG_QUANTUM, q);
            write_reg(REG_HEADER, hdr_len);
            q_eff = (q == 0) ? 1 : q;
            low_slot = (hdr_len == 0) ? 0 : (hdr_len + q_eff - 1) / q_eff - 1;
            if (low_slot > SLOTS - 1)
                low_slot = SLOTS - 1;
            send_req(ACT_INIT, $urandom_range(0, OFF_MAX));
            allocs = 0;
            for (i = 1; i < PHASE_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    send_req(ACT_ALLOC, $urandom_range(0, OFF_MAX));
                    allocs++;
                end
                else if (r < 85)
                begin
                    // aim at a slot that was likely handed out, sometimes mid-slot
                    chunk = (low_slot + $urandom_range(0, allocs + 1) + 1) * q_eff;
                    if ($urandom_range(0, 1) == 1)
                        chunk += $urandom_range(0, q_eff - 1);
                    send_req(ACT_FREE, chunk);
                end
                else if (r < 92)
                    send_req(ACT_FREE, $urandom_range(0, OFF_MAX));
                else if (r < 96)
                    send_req(ACT_UNUSED, $urandom_range(0, OFF_MAX));
                else
                begin
                    send_req(ACT_INIT, $urandom_range(0, OFF_MAX));
                    allocs = 0;
                end
            end
        end

        // Drain and settle
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== bitmap_slot_allocator_top.f =====
hw/rtl/bsa_pkg.sv
hw/rtl/bitmap_slot_allocator_top.sv
test/slot_alloc_checker.sv
test/tb_bitmap_slot_allocator_top.sv
